// ----- rtl/lcpie_pkg.sv -----
// Shared constants and types for the LCP interval enumerator.
package lcpie_pkg;

   // Stack and field sizes.
   localparam int STACK_DEPTH = 64;
   localparam int INDEX_BITS  = 20;
   localparam int FIELD_BITS  = 20;
   localparam int TOP_BITS    = $clog2(STACK_DEPTH);
   localparam int ENTRY_BITS  = FIELD_BITS + INDEX_BITS;

   // Highest stack level that can hold an open interval.
   localparam logic [TOP_BITS-1:0] TOP_MAX = TOP_BITS'(STACK_DEPTH - 1);

   typedef logic [FIELD_BITS-1:0] length_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [TOP_BITS-1:0]   level_type;

   // One open interval as kept in the stack memory.
   typedef struct packed {
      length_type len;
      index_type  lb;
   } entry_type;

endpackage

// ----- rtl/lcpie_ram.sv -----
// Generic single-port RAM with registered read data.
module lcpie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on request, otherwise register the read word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lcp_interval_enumerator.sv -----
// Top level of the LCP interval enumerator: stack sequencer and result register.
//
//  Channel | Direction | Ports                                         | Handshake
//  req     | in        | req_lcp_value, req_end_of_array               | req_valid / req_stall
//  rsp     | out       | rsp_interval_length, rsp_left_bound,          | rsp_valid / rsp_stall
//          |           | rsp_right_bound, rsp_run_last, rsp_stack_overflow
//
// An item that closes no interval takes the transfer and one compare step.
// Each closed interval adds three steps (compare, stack read, result) plus any output stall.
// The single-port stack memory with its registered read sets the pace of each pop.
// Reset is synchronous; an end-of-array item flushes and then returns all state to reset.
// The input is stalled from the transfer until the last result of that item is taken.
module lcp_interval_enumerator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lcpie_pkg::FIELD_BITS-1:0] req_lcp_value,
   input  logic                          req_end_of_array,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lcpie_pkg::FIELD_BITS-1:0] rsp_interval_length,
   output logic [lcpie_pkg::FIELD_BITS-1:0] rsp_left_bound,
   output logic [lcpie_pkg::FIELD_BITS-1:0] rsp_right_bound,
   output logic                          rsp_run_last,
   output logic                          rsp_stack_overflow
);

   // Sequencer state codes.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_LOAD  = 2'd2;
   localparam logic [1:0] S_WAIT  = 2'd3;

   logic [1:0] state_ff, state_in;

   // Item registers.
   lcpie_pkg::length_type v_ff, v_in;
   logic                  end_ff, end_in;
   lcpie_pkg::index_type  right_ff, right_in;
   lcpie_pkg::index_type  lb_ff, lb_in;
   logic                  flag_ff, flag_in;

   // Stack state: the top entry is cached, entries below live in memory.
   lcpie_pkg::level_type  top_ff, top_in;
   lcpie_pkg::length_type top_len_ff, top_len_in;
   lcpie_pkg::index_type  top_lb_ff, top_lb_in;
   lcpie_pkg::index_type  position_ff, position_in;
   logic                  overflow_ff, overflow_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   lcpie_pkg::length_type rsp_len_ff, rsp_len_in;
   lcpie_pkg::length_type rsp_lb_ff, rsp_lb_in;
   lcpie_pkg::length_type rsp_right_ff, rsp_right_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_flag_ff, rsp_flag_in;

   // Memory port.
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   lcpie_pkg::level_type  ram_addr;
   lcpie_pkg::entry_type  ram_wr_data;
   lcpie_pkg::entry_type  ram_rd_data;

   // Shared compare unit and the entry that becomes top after a pop.
   lcpie_pkg::length_type new_len;
   lcpie_pkg::index_type  new_lb;
   lcpie_pkg::length_type cmp_len;
   logic                  cmp_lt;
   logic                  cmp_gt;
   logic                  pop_now;
   logic                  req_xfer;
   logic                  rsp_xfer;

   lcpie_ram #(
      .WIDTH (lcpie_pkg::ENTRY_BITS),
      .DEPTH (lcpie_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // The root at level zero is always length zero with left bound zero.
   assign new_len = (top_ff == '0) ? '0 : ram_rd_data.len;
   assign new_lb  = (top_ff == '0) ? '0 : ram_rd_data.lb;

   // One comparator serves the pop test and the run-last lookahead.
   assign cmp_len = (state_ff == S_LOAD) ? new_len : top_len_ff;
   assign cmp_lt  = (v_ff < cmp_len);
   assign cmp_gt  = (v_ff > cmp_len);
   assign pop_now = (top_ff != '0) && cmp_lt;

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      end_in       = end_ff;
      right_in     = right_ff;
      lb_in        = lb_ff;
      flag_in      = flag_ff;
      top_in       = top_ff;
      top_len_in   = top_len_ff;
      top_lb_in    = top_lb_ff;
      position_in  = position_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_lb_in    = rsp_lb_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_flag_in  = rsp_flag_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_addr     = top_ff;
      ram_wr_data  = '{len: top_len_ff, lb: top_lb_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               v_in     = req_end_of_array ? '0 : req_lcp_value;
               end_in   = req_end_of_array;
               right_in = position_ff - lcpie_pkg::INDEX_BITS'(1);
               lb_in    = position_ff - lcpie_pkg::INDEX_BITS'(1);
               flag_in  = overflow_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (pop_now) begin
               // Close the top interval and fetch the one below it.
               rsp_len_in   = top_len_ff;
               rsp_lb_in    = lcpie_pkg::FIELD_BITS'(top_lb_ff);
               rsp_right_in = lcpie_pkg::FIELD_BITS'(right_ff);
               rsp_flag_in  = flag_ff;
               lb_in        = top_lb_ff;
               top_in       = top_ff - lcpie_pkg::TOP_BITS'(1);
               ram_rd_en    = 1'b1;
               ram_addr     = top_ff - lcpie_pkg::TOP_BITS'(1);
               state_in     = S_LOAD;
            end else begin
               // Open a new interval if the value is above the top; at full depth set overflow instead.
               if (cmp_gt) begin
                  if (top_ff != lcpie_pkg::TOP_MAX) begin
                     ram_wr_en  = 1'b1;
                     top_in     = top_ff + lcpie_pkg::TOP_BITS'(1);
                     top_len_in = v_ff;
                     top_lb_in  = lb_ff;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               position_in = position_ff + lcpie_pkg::INDEX_BITS'(1);
               if (end_ff) begin
                  top_in      = '0;
                  top_len_in  = '0;
                  top_lb_in   = '0;
                  position_in = lcpie_pkg::INDEX_BITS'(1);
                  overflow_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         S_LOAD: begin
            // New top arrives; the run ends unless it too will close.
            top_len_in   = new_len;
            top_lb_in    = new_lb;
            rsp_last_in  = !((top_ff != '0) && cmp_lt);
            rsp_valid_in = 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               state_in     = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         top_len_ff   <= '0;
         top_lb_ff    <= '0;
         position_ff  <= lcpie_pkg::INDEX_BITS'(1);
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         top_len_ff   <= top_len_in;
         top_lb_ff    <= top_lb_in;
         position_ff  <= position_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      end_ff       <= end_in;
      right_ff     <= right_in;
      lb_ff        <= lb_in;
      flag_ff      <= flag_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_lb_ff    <= rsp_lb_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_interval_length = rsp_len_ff;
   assign rsp_left_bound      = rsp_lb_ff;
   assign rsp_right_bound     = rsp_right_ff;
   assign rsp_run_last        = rsp_last_ff;
   assign rsp_stack_overflow  = rsp_flag_ff;

   // A result is only shown while the sequencer waits for its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_WAIT))
      else $error("result valid outside the wait state");

   // A pop lowers the stack by exactly one level.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && pop_now) |=> (top_ff == $past(top_ff) - lcpie_pkg::TOP_BITS'(1)))
      else $error("pop did not lower the stack by one");

   // Finishing an end-of-array item leaves only the root and restarts the position.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && !pop_now && end_ff)
      |=> (top_ff == '0 && position_ff == lcpie_pkg::INDEX_BITS'(1) && !overflow_ff))
      else $error("end of array did not restore the reset state");

   // The input side is open only when no result is pending.
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid_ff)
      else $error("input accepted while a result is pending");

endmodule

// ----- tb/sv/lcp_interval_enumerator_tb.sv -----
// Self-checking testbench for the LCP interval enumerator: directed table and random runs.
`timescale 1ns / 100ps

module lcp_interval_enumerator_tb;

   // One closed interval as it leaves the block.
   typedef struct packed {
      logic [lcpie_pkg::FIELD_BITS-1:0] len;
      logic [lcpie_pkg::FIELD_BITS-1:0] lb;
      logic [lcpie_pkg::FIELD_BITS-1:0] rb;
      logic                             last;
      logic                             ovf;
   } interval_type;

   // One row of the directed table; a typed row carries its single closed interval.
   typedef struct packed {
      lcpie_pkg::length_type lcp;
      logic                  at_end;
      logic                  typed;
      interval_type          want;
   } stim_row_type;

   localparam interval_type UNTYPED       = '0;
   localparam int           NUM_ROWS      = 17;
   localparam int           RANDOM_ITEMS  = 90;
   localparam int           LONG_HOLD     = 60;
   localparam int           SETTLE_CYCLES = 8;
   localparam int           QUIET_LIMIT   = 2000;

   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{20'h00003, 1'b0, 1'b0, UNTYPED},
      '{20'h00001, 1'b0, 1'b1, '{20'h00003, 20'h00000, 20'h00001, 1'b1, 1'b0}},
      '{20'hFFFFF, 1'b0, 1'b0, UNTYPED},
      '{20'hFFFFF, 1'b0, 1'b0, UNTYPED},
      '{20'hFFFFF, 1'b1, 1'b0, UNTYPED},
      '{20'h00000, 1'b0, 1'b0, UNTYPED},
      '{20'h00000, 1'b1, 1'b0, UNTYPED},
      '{20'h80000, 1'b0, 1'b0, UNTYPED},
      '{20'h7FFFF, 1'b0, 1'b1, '{20'h80000, 20'h00000, 20'h00001, 1'b1, 1'b0}},
      '{20'h00001, 1'b0, 1'b1, '{20'h7FFFF, 20'h00000, 20'h00002, 1'b1, 1'b0}},
      '{20'h55555, 1'b0, 1'b0, UNTYPED},
      '{20'hAAAAA, 1'b0, 1'b0, UNTYPED},
      '{20'h55555, 1'b0, 1'b1, '{20'hAAAAA, 20'h00004, 20'h00005, 1'b1, 1'b0}},
      '{20'h00002, 1'b0, 1'b1, '{20'h55555, 20'h00003, 20'h00006, 1'b1, 1'b0}},
      '{20'h00000, 1'b0, 1'b0, UNTYPED},
      '{20'h00000, 1'b1, 1'b0, UNTYPED},
      '{20'h00001, 1'b1, 1'b0, UNTYPED}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   lcpie_pkg::length_type req_lcp_value = '0;
   logic                  req_end_of_array = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   lcpie_pkg::length_type rsp_interval_length;
   lcpie_pkg::length_type rsp_left_bound;
   lcpie_pkg::length_type rsp_right_bound;
   logic                  rsp_run_last;
   logic                  rsp_stack_overflow;

   // Model state: open intervals, position counter and sticky overflow.
   lcpie_pkg::length_type open_len [lcpie_pkg::STACK_DEPTH];
   lcpie_pkg::index_type  open_lb  [lcpie_pkg::STACK_DEPTH];
   int                    open_top;
   lcpie_pkg::index_type  next_pos;
   logic                  overflow_flag;

   interval_type intervals_due [$];
   int           error_count = 0;
   bit           idle_on = 1'b1;
   bit           hold_pending = 1'b0;

   lcp_interval_enumerator uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_lcp_value       (req_lcp_value),
      .req_end_of_array    (req_end_of_array),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_interval_length (rsp_interval_length),
      .rsp_left_bound      (rsp_left_bound),
      .rsp_right_bound     (rsp_right_bound),
      .rsp_run_last        (rsp_run_last),
      .rsp_stack_overflow  (rsp_stack_overflow)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Return the interval stack to its state after reset: only the root open.
   task automatic clear_open_intervals();
      for (int i = 0; i < lcpie_pkg::STACK_DEPTH; i++) begin
         open_len[i] = '0;
         open_lb[i]  = '0;
      end
      open_top      = 0;
      next_pos      = lcpie_pkg::index_type'(1);
      overflow_flag = 1'b0;
   endtask

   // Close every open interval longer than the new value, then open one if it rises.
   task automatic track_intervals(input lcpie_pkg::length_type value, input logic at_end);
      lcpie_pkg::length_type key;
      lcpie_pkg::index_type  right;
      lcpie_pkg::index_type  left;
      interval_type          closed;
      key   = at_end ? '0 : value;
      right = next_pos - lcpie_pkg::index_type'(1);
      left  = right;
      while (open_top > 0 && key < open_len[open_top]) begin
         closed.len  = open_len[open_top];
         closed.lb   = lcpie_pkg::length_type'(open_lb[open_top]);
         closed.rb   = lcpie_pkg::length_type'(right);
         closed.last = !(open_top > 1 && key < open_len[open_top - 1]);
         closed.ovf  = overflow_flag;
         intervals_due.insert(intervals_due.size(), closed);
         left = open_lb[open_top];
         open_top--;
      end
      if (key > open_len[open_top]) begin
         if (open_top + 1 < lcpie_pkg::STACK_DEPTH) begin
            open_top++;
            open_len[open_top] = key;
            open_lb[open_top]  = left;
         end else begin
            overflow_flag = 1'b1;
         end
      end
      next_pos = next_pos + lcpie_pkg::index_type'(1);
      if (at_end) begin
         clear_open_intervals();
      end
   endtask

   // Offer one item after a random gap and wait for its transfer.
   task automatic send_item(input lcpie_pkg::length_type value, input logic at_end,
                            input logic typed, input interval_type want);
      int gap;
      int due_count;
      gap = idle_on ? $urandom_range(3, 0) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_lcp_value    <= value;
      req_end_of_array <= at_end;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      due_count = intervals_due.size();
      track_intervals(value, at_end);
      // A typed row replaces what the model worked out with the value from the table.
      if (typed) begin
         while (intervals_due.size() > due_count) begin
            intervals_due.delete(intervals_due.size() - 1);
         end
         intervals_due.insert(intervals_due.size(), want);
      end
      @(negedge clock);
   endtask

   // Hold the input quiet until every pending interval has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (intervals_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void check_field(input string label,
                                       input logic [lcpie_pkg::FIELD_BITS-1:0] want,
                                       input logic [lcpie_pkg::FIELD_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", label, want, got);
         error_count++;
      end
   endfunction

   // Result side: random stalls per transfer, with one long hold on request.
   initial begin : result_sink
      int hold;
      forever begin
         if (hold_pending) begin
            hold         = LONG_HOLD;
            hold_pending = 1'b0;
         end else begin
            hold = idle_on ? $urandom_range(3, 0) : 0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Compare each result transfer with the oldest pending interval.
   always @(posedge clock) begin : result_check
      interval_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (intervals_due.size() == 0) begin
            $error("result with no pending interval: length %h left %h right %h",
                   rsp_interval_length, rsp_left_bound, rsp_right_bound);
            error_count++;
         end else begin
            want = intervals_due.pop_front();
            check_field("interval_length", want.len, rsp_interval_length);
            check_field("left_bound", want.lb, rsp_left_bound);
            check_field("right_bound", want.rb, rsp_right_bound);
            check_field("run_last", lcpie_pkg::FIELD_BITS'(want.last),
                        lcpie_pkg::FIELD_BITS'(rsp_run_last));
            check_field("stack_overflow", lcpie_pkg::FIELD_BITS'(want.ovf),
                        lcpie_pkg::FIELD_BITS'(rsp_stack_overflow));
         end
      end
   end

   // Watchdog: too long without any transfer on either side ends the run.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("lcp_interval_enumerator_tb: errors");
      $finish;
   end

   initial begin : stimulus
      int                    sent;
      int                    run_len;
      bit                    paused;
      lcpie_pkg::length_type value;
      lcpie_pkg::length_type prev;
      clear_open_intervals();
      sent   = 0;
      paused = 1'b0;
      prev   = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed table: extremes, nesting, end flag with a live value.
      for (int r = 0; r < NUM_ROWS; r++) begin
         send_item(DIRECTED_ROWS[r].lcp, DIRECTED_ROWS[r].at_end,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end

      // Rising ramp past the stack depth, then one value that closes every level.
      for (int k = 1; k <= lcpie_pkg::STACK_DEPTH + 2; k++) begin
         send_item(lcpie_pkg::length_type'(k), 1'b0, 1'b0, UNTYPED);
      end
      hold_pending = 1'b1;
      send_item('0, 1'b0, 1'b0, UNTYPED);
      send_item(lcpie_pkg::length_type'(5), 1'b0, 1'b0, UNTYPED);
      send_item(lcpie_pkg::length_type'(3), 1'b0, 1'b0, UNTYPED);
      send_item(lcpie_pkg::length_type'(7), 1'b1, 1'b0, UNTYPED);
      // The end item clears the sticky flag for what follows.
      send_item(lcpie_pkg::length_type'(2), 1'b0, 1'b0, UNTYPED);
      send_item(lcpie_pkg::length_type'(1), 1'b0, 1'b0, UNTYPED);

      // Random runs closed by an end item, mixed with isolated noise items.
      while (sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(3, 0) != 0);
         if ($urandom_range(4, 0) == 0) begin
            send_item(lcpie_pkg::length_type'($urandom), $urandom_range(7, 0) == 0,
                      1'b0, UNTYPED);
            sent++;
         end else begin
            run_len = $urandom_range(20, 3);
            for (int k = 0; k < run_len; k++) begin
               case ($urandom_range(9, 0))
                  6: value = lcpie_pkg::length_type'($urandom);
                  7: value = lcpie_pkg::length_type'(20'hFFFFF - $urandom_range(3, 0));
                  8: value = prev + lcpie_pkg::length_type'(1);
                  9: value = prev;
                  default: value = lcpie_pkg::length_type'($urandom_range(7, 0));
               endcase
               send_item(value, 1'b0, 1'b0, UNTYPED);
               prev = value;
               sent++;
            end
            send_item(lcpie_pkg::length_type'($urandom), 1'b1, 1'b0, UNTYPED);
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end

      drain_results();
      if (error_count == 0) begin
         $display("lcp_interval_enumerator_tb: clean");
      end else begin
         $display("lcp_interval_enumerator_tb: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lcpie_pkg.sv
rtl/lcpie_ram.sv
rtl/lcp_interval_enumerator.sv
tb/sv/lcp_interval_enumerator_tb.sv
